// ===== design/ffa_pkg.sv =====
// Shared types, constants and micro-operation codes for the free-list allocator.
package ffa_pkg;

  localparam int AddrW      = 14;
  localparam int ReqW       = 18;
  localparam int GrowW      = 15;
  localparam int UnitBytes  = 16;
  localparam int UbShift    = $clog2(UnitBytes);
  localparam int ArenaUnits = 16384;
  localparam int NumW       = ReqW - UbShift + 2;
  localparam logic [GrowW-1:0] GrowReset = GrowW'(1024);

  typedef struct packed {
    logic            kind;
    logic [ReqW-1:0] request_bytes;
    logic [AddrW-1:0] block_address;
  } ffa_in_t;

  typedef struct packed {
    logic             status;
    logic [AddrW-1:0] user_address;
  } ffa_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_A_START,
    OP_A_LOAD,
    OP_A_EXACT,
    OP_A_CARVE,
    OP_A_CARVE2,
    OP_A_ADV,
    OP_A_FAIL,
    OP_GROW,
    OP_G_RET,
    OP_F_START,
    OP_F_STEP,
    OP_F_EXIT,
    OP_F_HI_RD,
    OP_F_HI_WR,
    OP_F_HI_NO,
    OP_F_LO0,
    OP_F_LO_RD,
    OP_F_LO_WR,
    OP_F_LO_NO
  } ffa_op_e;

  typedef struct packed {
    ffa_op_e op;
    logic    load_out;
  } ffa_cmd_t;

  typedef struct packed {
    logic kind_free;
    logic started;
    logic free_ok;
    logic fit_exact;
    logic fit_carve;
    logic at_rover;
    logic a_step_over;
    logic grow_ok;
    logic f_exit;
    logic f_step_over;
    logic merge_hi;
    logic merge_lo;
    logic ret;
  } ffa_sts_t;

endpackage

// ===== design/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/ffa_dp.sv =====
// Datapath of the allocator: heap memories, list pointers and result register.
module ffa_dp #(
  parameter int ARENA_UNITS = ffa_pkg::ArenaUnits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffa_pkg::ffa_cmd_t           cmd_i,
  input  ffa_pkg::ffa_in_t            in_data_i,
  input  logic [ffa_pkg::GrowW-1:0]   min_grow_i,
  output ffa_pkg::ffa_sts_t           sts_o,
  output ffa_pkg::ffa_out_t           out_data_o
);
  import ffa_pkg::*;

  localparam int AW  = $clog2(ARENA_UNITS);
  localparam int SW  = AW + 1;
  localparam int CW  = ((SW > NumW) ? SW : NumW) + 1;
  localparam int WSW = AW + 3;
  localparam int FSW = AW + 2;
  localparam logic [CW-1:0]  ArenaC = CW'(ARENA_UNITS);
  localparam logic [WSW-1:0] WLim   = WSW'(2 * ARENA_UNITS + 4);
  localparam logic [FSW-1:0] FLim   = FSW'(ARENA_UNITS + 1);

  logic [AW-1:0]    next_rd;
  logic [SW-1:0]    size_rd;
  logic             we_n, we_s;
  logic [AW-1:0]    wa_n, wa_s, ra;
  logic [AW-1:0]    wd_n;
  logic [SW-1:0]    wd_s;

  logic             started_q, ret_q;
  logic [AW-1:0]    rover_q;
  logic [SW-1:0]    heap_q;
  logic             kind_q, free_ok_q, res_status_q;
  logic [AddrW-1:0] res_addr_q;
  logic [AW-1:0]    p_q, prev_q, q_q, b_q;
  logic [NumW-1:0]  n_q;
  logic [SW-1:0]    sb_q, sp_q;
  logic [WSW-1:0]   wstep_q;
  logic [FSW-1:0]   fstep_q;
  ffa_out_t         out_q;

  logic [CW-1:0]    sz_c, n_c, p_c, rest_c, addr_c;
  logic [NumW-1:0]  nu, grow_c, req_units;

  ffa_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS)) u_next_ram (
    .clk_i, .we_i(we_n), .waddr_i(wa_n), .wdata_i(wd_n), .raddr_i(ra), .rdata_o(next_rd)
  );

  ffa_ram #(.WIDTH(SW), .DEPTH(ARENA_UNITS)) u_size_ram (
    .clk_i, .we_i(we_s), .waddr_i(wa_s), .wdata_i(wd_s), .raddr_i(ra), .rdata_o(size_rd)
  );

  always_comb begin
    sz_c      = CW'(size_rd);
    n_c       = CW'(n_q);
    p_c       = CW'(p_q);
    rest_c    = sz_c - n_c;
    addr_c    = CW'(in_data_i.block_address);
    grow_c    = NumW'(min_grow_i);
    nu        = (n_q >= grow_c) ? n_q : grow_c;
    req_units = NumW'(((ReqW + 1)'(in_data_i.request_bytes) + (ReqW + 1)'(UnitBytes - 1))
                      >> UbShift) + NumW'(1);

    sts_o.kind_free   = kind_q;
    sts_o.started     = started_q;
    sts_o.free_ok     = free_ok_q;
    sts_o.fit_exact   = (sz_c == n_c);
    sts_o.fit_carve   = (sz_c > n_c) && ((p_c + rest_c) < ArenaC);
    sts_o.at_rover    = (p_q == rover_q);
    sts_o.a_step_over = (wstep_q >= WLim);
    sts_o.grow_ok     = (CW'(heap_q) + CW'(nu)) <= ArenaC;
    sts_o.f_exit      = ((b_q > p_q) && (b_q < next_rd)) ||
                        ((p_q >= next_rd) && ((b_q > p_q) || (b_q < next_rd)));
    sts_o.f_step_over = (fstep_q >= FLim);
    sts_o.merge_hi    = (CW'(b_q) + sz_c) == CW'(q_q);
    sts_o.merge_lo    = (p_c + sz_c) == CW'(b_q);
    sts_o.ret         = ret_q;

    ra   = p_q;
    we_n = 1'b0;
    wa_n = p_q;
    wd_n = next_rd;
    we_s = 1'b0;
    wa_s = p_q;
    wd_s = size_rd;
    case (cmd_i.op)
      OP_INIT: begin
        we_n = 1'b1;
        wa_n = '0;
        wd_n = '0;
        we_s = 1'b1;
        wa_s = '0;
        wd_s = '0;
      end
      OP_A_START, OP_G_RET, OP_F_START: ra = rover_q;
      OP_A_LOAD, OP_A_ADV, OP_F_STEP:   ra = next_rd;
      OP_A_EXACT: begin
        we_n = 1'b1;
        wa_n = prev_q;
        wd_n = next_rd;
      end
      OP_A_CARVE: begin
        we_s = 1'b1;
        wd_s = SW'(rest_c);
      end
      OP_A_CARVE2: begin
        we_s = 1'b1;
        wd_s = SW'(n_q);
      end
      OP_GROW: begin
        we_s = 1'b1;
        wa_s = heap_q[AW-1:0];
        wd_s = SW'(nu);
      end
      OP_F_EXIT, OP_F_LO_RD: ra = b_q;
      OP_F_HI_RD: ra = q_q;
      OP_F_HI_WR: begin
        we_s = 1'b1;
        wa_s = b_q;
        wd_s = sb_q + size_rd;
        we_n = 1'b1;
        wa_n = b_q;
        wd_n = next_rd;
      end
      OP_F_HI_NO: begin
        we_n = 1'b1;
        wa_n = b_q;
        wd_n = q_q;
      end
      OP_F_LO_WR: begin
        we_s = 1'b1;
        wd_s = sp_q + size_rd;
        we_n = 1'b1;
      end
      OP_F_LO_NO: begin
        we_n = 1'b1;
        wd_n = b_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rover_q   <= '0;
      heap_q    <= SW'(1);
      ret_q     <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_ACCEPT: ret_q <= 1'b0;
        OP_INIT: begin
          started_q <= 1'b1;
          rover_q   <= '0;
        end
        OP_A_EXACT, OP_A_CARVE: rover_q <= prev_q;
        OP_GROW: begin
          heap_q <= SW'(CW'(heap_q) + CW'(nu));
          ret_q  <= 1'b1;
        end
        OP_F_LO_WR, OP_F_LO_NO: rover_q <= p_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        kind_q       <= in_data_i.kind;
        n_q          <= req_units;
        b_q          <= AW'(addr_c - CW'(1));
        free_ok_q    <= started_q && (in_data_i.block_address != '0) &&
                        ((addr_c - CW'(1)) < ArenaC);
        res_status_q <= 1'b0;
        res_addr_q   <= '0;
      end
      OP_A_START: begin
        prev_q  <= rover_q;
        wstep_q <= '0;
      end
      OP_A_LOAD: p_q <= next_rd;
      OP_A_EXACT, OP_A_CARVE2: res_addr_q <= AddrW'(p_c + CW'(1));
      OP_A_CARVE: p_q <= AW'(p_c + rest_c);
      OP_A_ADV: begin
        wstep_q <= wstep_q + WSW'(1);
        prev_q  <= p_q;
        p_q     <= next_rd;
      end
      OP_A_FAIL: begin
        res_status_q <= 1'b1;
        res_addr_q   <= '0;
      end
      OP_GROW: b_q <= heap_q[AW-1:0];
      OP_G_RET: begin
        wstep_q <= wstep_q + WSW'(1);
        prev_q  <= rover_q;
      end
      OP_F_START: begin
        p_q     <= rover_q;
        fstep_q <= '0;
      end
      OP_F_STEP: begin
        p_q     <= next_rd;
        fstep_q <= fstep_q + FSW'(1);
      end
      OP_F_EXIT:  q_q  <= next_rd;
      OP_F_HI_RD: sb_q <= size_rd;
      OP_F_LO_RD: sp_q <= size_rd;
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_q.status       <= res_status_q;
      out_q.user_address <= res_addr_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/ffa_ctrl.sv =====
// Controller state machine that sequences the allocator datapath.
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ffa_pkg::ffa_sts_t sts_i,
  output ffa_pkg::ffa_cmd_t cmd_o
);
  import ffa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INIT, S_A_START, S_A_LOAD, S_A_CHK, S_A_CARVE2, S_G_RET,
    S_F_START, S_F_CHK, S_F_SB, S_F_HI_WR, S_F_LO0, S_F_SP, S_F_LO_WR, S_RET, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.load_out = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.kind_free) begin
          state_d = sts_i.started ? S_A_START : S_INIT;
        end else begin
          state_d = sts_i.free_ok ? S_F_START : S_DONE;
        end
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_A_START;
      end
      S_A_START: begin
        cmd_o.op = OP_A_START;
        state_d  = S_A_LOAD;
      end
      S_A_LOAD: begin
        cmd_o.op = OP_A_LOAD;
        state_d  = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts_i.fit_exact) begin
          cmd_o.op = OP_A_EXACT;
          state_d  = S_DONE;
        end else if (sts_i.fit_carve) begin
          cmd_o.op = OP_A_CARVE;
          state_d  = S_A_CARVE2;
        end else if (sts_i.at_rover) begin
          if (sts_i.grow_ok) begin
            cmd_o.op = OP_GROW;
            state_d  = S_F_START;
          end else begin
            cmd_o.op = OP_A_FAIL;
            state_d  = S_DONE;
          end
        end else if (sts_i.a_step_over) begin
          cmd_o.op = OP_A_FAIL;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_A_ADV;
        end
      end
      S_A_CARVE2: begin
        cmd_o.op = OP_A_CARVE2;
        state_d  = S_DONE;
      end
      S_G_RET: begin
        if (sts_i.a_step_over) begin
          cmd_o.op = OP_A_FAIL;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_G_RET;
          state_d  = S_A_LOAD;
        end
      end
      S_F_START: begin
        cmd_o.op = OP_F_START;
        state_d  = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts_i.f_exit) begin
          cmd_o.op = OP_F_EXIT;
          state_d  = S_F_SB;
        end else if (sts_i.f_step_over) begin
          state_d = S_RET;
        end else begin
          cmd_o.op = OP_F_STEP;
        end
      end
      S_F_SB: begin
        if (sts_i.merge_hi) begin
          cmd_o.op = OP_F_HI_RD;
          state_d  = S_F_HI_WR;
        end else begin
          cmd_o.op = OP_F_HI_NO;
          state_d  = S_F_LO0;
        end
      end
      S_F_HI_WR: begin
        cmd_o.op = OP_F_HI_WR;
        state_d  = S_F_LO0;
      end
      S_F_LO0: begin
        cmd_o.op = OP_F_LO0;
        state_d  = S_F_SP;
      end
      S_F_SP: begin
        if (sts_i.merge_lo) begin
          cmd_o.op = OP_F_LO_RD;
          state_d  = S_F_LO_WR;
        end else begin
          cmd_o.op = OP_F_LO_NO;
          state_d  = S_RET;
        end
      end
      S_F_LO_WR: begin
        cmd_o.op = OP_F_LO_WR;
        state_d  = S_RET;
      end
      S_RET: begin
        state_d = sts_i.ret ? S_G_RET : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list heap allocator.
// Usage:
// An input beat carries kind (allocate or free), request_bytes and block_address.
// Each input beat yields exactly one output beat with status and user_address.
// Input is taken while in_stall_o is low; one item is processed at a time.
// An allocate walks the circular free list through the link and size memories;
// growing the heap adds a free-list insertion walk. A free also walks the list.
// The free-list length therefore sets the latency; an ignored free skips the
// walk, and an allocate that fits the first block it visits stops there.
// A finished result sits in an output register; the next input beat is taken
// while it waits, and the block holds a new result until the old one is taken.
// Reset empties the free list, sets the break to unit one and min_grow_units to
// 1024; the heap memories need no clearing pass.
// The user writes min_grow_units over the APB port at address zero while idle; the block does not enforce this.
module first_fit_free_list_allocator #(
  parameter int ARENA_UNITS = ffa_pkg::ArenaUnits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ffa_pkg::ffa_in_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ffa_pkg::ffa_out_t     out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ffa_pkg::*;

  logic [GrowW-1:0] min_grow_q;
  ffa_cmd_t         cmd;
  ffa_sts_t         sts;

  assign pready      = 1'b1;
  assign prdata      = 32'(min_grow_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_grow_q <= GrowReset;
    end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      min_grow_q <= pwdata[GrowW-1:0];
    end
  end

  ffa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ffa_dp #(.ARENA_UNITS(ARENA_UNITS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .in_data_i,
    .min_grow_i (min_grow_q),
    .sts_o      (sts),
    .out_data_o
  );

endmodule

// ===== tb/sv/ffa_heap_checker.sv =====
// Checker that predicts allocator results from observed beats and compares them.
`timescale 1ns / 1ps
module ffa_heap_checker
  import ffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  ffa_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  ffa_out_t    out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o
);

  localparam int unsigned WalkLimit = 2 * ArenaUnits + 4;

  logic [AddrW-1:0] link_mem [ArenaUnits];
  logic [GrowW-1:0] size_mem [ArenaUnits];
  logic [AddrW-1:0] rover_q;
  logic             started_q;
  logic [GrowW-1:0] brk_q;
  logic [GrowW-1:0] min_grow_q;
  ffa_out_t         expected_q[$];

  function automatic void insert_free(int unsigned b);
    int unsigned p;
    int unsigned q;
    int unsigned steps;
    p = rover_q;
    steps = 0;
    while (!(b > p && b < int'(link_mem[p]))) begin
      if (p >= link_mem[p] && (b > p || b < link_mem[p])) break;
      p = link_mem[p];
      steps++;
      if (steps > ArenaUnits + 1) return;
    end
    q = link_mem[p];
    if (b + size_mem[b] == q) begin
      size_mem[b] = size_mem[b] + size_mem[q];
      link_mem[b] = link_mem[q];
    end else begin
      link_mem[b] = q;
    end
    if (p + size_mem[p] == b) begin
      size_mem[p] = size_mem[p] + size_mem[b];
      link_mem[p] = link_mem[b];
    end else begin
      link_mem[p] = b;
    end
    rover_q = p;
  endfunction

  function automatic bit grow_heap(int unsigned units);
    int unsigned nu;
    int unsigned up;
    nu = (units < min_grow_q) ? min_grow_q : units;
    up = brk_q;
    if (up + nu > ArenaUnits) return 1'b0;
    brk_q = up + nu;
    size_mem[up] = nu;
    insert_free(up);
    return 1'b1;
  endfunction

  function automatic ffa_out_t alloc_units(int unsigned bytes);
    ffa_out_t    r;
    int unsigned n;
    int unsigned prev;
    int unsigned p;
    int unsigned rest;
    int unsigned steps;
    r = '0;
    n = (bytes + UnitBytes - 1) / UnitBytes + 1;
    steps = 0;
    if (!started_q) begin
      link_mem[0] = '0;
      size_mem[0] = '0;
      rover_q = '0;
      started_q = 1'b1;
    end
    prev = rover_q;
    p = link_mem[prev];
    forever begin
      if (size_mem[p] >= n) begin
        rest = size_mem[p] - n;
        if (rest == 0) begin
          link_mem[prev] = link_mem[p];
          rover_q = prev;
          r.user_address = AddrW'(p + 1);
          return r;
        end
        if (p + rest < ArenaUnits) begin
          size_mem[p] = rest;
          p = p + rest;
          size_mem[p] = n;
          rover_q = prev;
          r.user_address = AddrW'(p + 1);
          return r;
        end
      end
      if (p == rover_q) begin
        if (!grow_heap(n)) begin
          r.status = 1'b1;
          return r;
        end
        p = rover_q;
      end
      steps++;
      if (steps > WalkLimit) begin
        r.status = 1'b1;
        return r;
      end
      prev = p;
      p = link_mem[p];
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ffa_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ArenaUnits; i++) begin
        link_mem[i] = '0;
        size_mem[i] = '0;
      end
      rover_q = '0;
      started_q = 1'b0;
      brk_q = GrowW'(1);
      min_grow_q = GrowReset;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'd0) min_grow_q = pwdata[GrowW-1:0];
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation: status %0d addr %0d",
                 out_data_i.status, out_data_i.user_address);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_data_i.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            fail_count_o++;
          end
          if (want.user_address !== out_data_i.user_address) begin
            $error("user_address: expected %0d, actual %0d",
                   want.user_address, out_data_i.user_address);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = '0;
        if (!in_data_i.kind) begin
          want = alloc_units(in_data_i.request_bytes);
        end else if (started_q && in_data_i.block_address != 0) begin
          insert_free(in_data_i.block_address - 1);
        end
        expected_q.push_back(want);
      end
    end
  end

  final begin
    if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the allocator testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ffa_pkg::*;

  localparam int StallLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  ffa_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  ffa_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          idle_in_pct;
  int          stall_pct;
  int          sent_cnt;
  int          recv_cnt;
  int          alloc_ok_cnt;
  int          oom_cnt;
  int          free_cnt;
  int          quiet_cycles;
  logic [AddrW-1:0] live_addrs[$];

  first_fit_free_list_allocator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ffa_heap_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (out_valid && !out_stall) begin
      recv_cnt <= recv_cnt + 1;
      if (out_data.status) oom_cnt <= oom_cnt + 1;
      else if (out_data.user_address != 0) begin
        alloc_ok_cnt <= alloc_ok_cnt + 1;
        live_addrs.push_back(out_data.user_address);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_beat(ffa_in_t d);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= d;
    forever begin
      @(negedge clk_i);
      if (!in_stall) begin
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
    sent_cnt++;
    if (d.kind) free_cnt++;
  endtask

  task automatic send_alloc(int unsigned bytes);
    ffa_in_t d;
    d = '0;
    d.request_bytes = ReqW'(bytes);
    d.block_address = AddrW'($urandom);
    send_beat(d);
  endtask

  task automatic send_free(logic [AddrW-1:0] a);
    ffa_in_t d;
    d = '0;
    d.kind = 1'b1;
    d.request_bytes = ReqW'($urandom);
    d.block_address = a;
    send_beat(d);
  endtask

  task automatic free_live();
    int idx;
    idx = $urandom_range(live_addrs.size() - 1);
    send_free(live_addrs[idx]);
    live_addrs.delete(idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (recv_cnt != sent_cnt) @(posedge clk_i);
  endtask

  task automatic write_min_grow(logic [31:0] v);
    drain();
    repeat (50) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) send_free('0);
      else if (roll < 48 && live_addrs.size() > 0) free_live();
      else if (roll < 88) send_alloc($urandom_range(400));
      else if (roll < 96) send_alloc($urandom_range(4000));
      else send_alloc($urandom_range(262143));
    end
  endtask

  initial begin
    int pct_in[4];
    int pct_st[4];
    logic [31:0] grow_val[4];
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_in_pct = 0;
    stall_pct = 0;
    sent_cnt = 0;
    recv_cnt = 0;
    alloc_ok_cnt = 0;
    oom_cnt = 0;
    free_cnt = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Frees before the list exists are ignored; they also toggle every address bit.
    send_free(AddrW'(14'h2AAA));
    send_free(AddrW'(14'h1555));
    send_free(AddrW'(14'h3FFF));
    send_alloc(0);
    send_alloc(1);
    send_alloc(16);
    send_alloc(17);
    send_alloc(262143);
    send_alloc(16 * 1023);
    send_alloc(4000);
    drain();
    send_free('0);
    while (live_addrs.size() > 0) free_live();
    send_alloc(16 * 1023);
    send_alloc(17);
    send_alloc(1);
    drain();
    while (live_addrs.size() > 0) free_live();
    send_alloc(32);

    pct_in = '{0, 80, 0, 37};
    pct_st = '{0, 0, 80, 37};
    grow_val = '{32'd1, 32'd16384, 32'($urandom_range(1, 16384)), 32'd1024};
    for (int ph = 0; ph < 4; ph++) begin
      write_min_grow(grow_val[ph]);
      idle_in_pct = pct_in[ph];
      stall_pct = pct_st[ph];
      random_items(160);
      idle_in_pct = 0;
      stall_pct = 0;
      random_items(160);
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items under four idle and stall mixes, min_grow 1 to 16384.",
             sent_cnt);
    $display("Allocations granted %0d, out of memory %0d, frees %0d.",
             alloc_ok_cnt, oom_cnt, free_cnt);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ffa_pkg.sv
design/ffa_ram.sv
design/ffa_dp.sv
design/ffa_ctrl.sv
design/first_fit_free_list_allocator.sv
tb/sv/ffa_heap_checker.sv
tb/sv/tb_top.sv
